// ===== rtl/core/ecpd_pkg.sv =====
// Package with field constants, opcodes and sequencer states for secp256k1 point doubling.
`default_nettype none
package ecpd_pkg;
    localparam int FE_W = 256;
    localparam int LIMB_W = 32;
    localparam int NLIMB = FE_W / LIMB_W;
    localparam int IDX_W = $clog2(NLIMB);
    localparam int PROD_LIMBS = 2 * NLIMB;
    localparam logic [FE_W-1:0] PRIME =
        256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
    // Exponent p - 2 for the inversion by Fermat's theorem.
    localparam logic [FE_W-1:0] INV_EXP =
        256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2D;
    localparam logic [10:0] FOLD_C = 11'd977;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB
    } op_t;

    typedef struct packed {
        logic start;
        op_t op;
    } alu_cmd_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_X2,
        S_L2,
        S_L3,
        S_Y2,
        S_INV_SQ,
        S_INV_MUL,
        S_LAM,
        S_LSQ,
        S_SUB1,
        S_SUB2,
        S_SUB3,
        S_YMUL,
        S_SUB4
    } state_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_PROD,
        M_RED,
        M_FOLD,
        M_FIN,
        M_ADDP
    } mstate_t;
endpackage
`default_nettype wire

// ===== rtl/core/ecpd_alu.sv =====
// Shared modular unit: limb-serial multiplier with reduction, plus add and subtract mod p.
`default_nettype none
module ecpd_alu (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ecpd_pkg::alu_cmd_t            cmd,
    input  wire logic [ecpd_pkg::FE_W-1:0]     a,
    input  wire logic [ecpd_pkg::FE_W-1:0]     b,
    output logic [ecpd_pkg::FE_W-1:0]          res,
    output logic                               done
);
    localparam int W = ecpd_pkg::FE_W;
    localparam int L = ecpd_pkg::LIMB_W;

    ecpd_pkg::mstate_t st_reg, st_next;
    logic [ecpd_pkg::IDX_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [ecpd_pkg::IDX_W:0] k_reg, k_next;
    logic [2*W-1:0] prod_reg, prod_next;
    logic [L-1:0] carry_reg, carry_next;
    logic [L+1:0] top_reg, top_next;
    logic [W:0] acc_reg, acc_next;
    logic [W-1:0] a_reg, b_reg;
    logic [W-1:0] res_reg, res_next;
    logic done_reg, done_next;

    logic [L-1:0] ai, bj, pl;
    logic [ecpd_pkg::IDX_W:0] ij;
    logic [2*L-1:0] pp, cur;
    logic [W:0] sum, diff;
    logic [ecpd_pkg::IDX_W:0] km1;
    logic [L-1:0] lo_k, hi_k, hi_km1;
    logic [L+10:0] hmul;
    logic [2*L-1:0] racc;
    logic [L+12:0] fmul;
    logic [W:0] fold_add, fsum;
    logic [W+1:0] csub;

    always_comb
    begin
        ai = a_reg[i_reg*L +: L];
        bj = b_reg[j_reg*L +: L];
        ij = {1'b0, i_reg} + {1'b0, j_reg};
        pl = prod_reg[ij*L +: L];
        pp = {{L{1'b0}}, ai} * {{L{1'b0}}, bj};
        cur = pp + {{L{1'b0}}, pl} + {{L{1'b0}}, carry_reg};
        sum = {1'b0, a} + {1'b0, b};
        diff = {1'b0, a} - {1'b0, b};
        // Limb k of low + hi*977 + hi*2^32, with the carry of the limb below.
        km1 = k_reg - 1'b1;
        lo_k = k_reg[ecpd_pkg::IDX_W] ? '0 : prod_reg[k_reg[ecpd_pkg::IDX_W-1:0]*L +: L];
        hi_k = k_reg[ecpd_pkg::IDX_W] ? '0
             : prod_reg[W + k_reg[ecpd_pkg::IDX_W-1:0]*L +: L];
        hi_km1 = (k_reg == '0) ? '0 : prod_reg[W + km1[ecpd_pkg::IDX_W-1:0]*L +: L];
        hmul = {11'd0, hi_k} * {{L{1'b0}}, ecpd_pkg::FOLD_C};
        racc = {{(L-2){1'b0}}, top_reg} + {{L{1'b0}}, lo_k}
             + {{(L-11){1'b0}}, hmul} + {{L{1'b0}}, hi_km1};
        // The part above 2^256 folds back as top*977 + top*2^32.
        fmul = {11'd0, top_reg} * {{(L+2){1'b0}}, ecpd_pkg::FOLD_C};
        fold_add = {{(W+1-(L+13)){1'b0}}, fmul}
                 + {{(W+1-(2*L+2)){1'b0}}, top_reg, {L{1'b0}}};
        fsum = {1'b0, acc_reg[W-1:0]} + fold_add;
        csub = {1'b0, acc_reg} - {2'b00, ecpd_pkg::PRIME};
    end

    // One 32x32 partial product per cycle, then one reduction limb per cycle.
    always_comb
    begin
        st_next = st_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        prod_next = prod_reg;
        carry_next = carry_reg;
        top_next = top_reg;
        acc_next = acc_reg;
        res_next = res_reg;
        done_next = 1'b0;
        case (st_reg)
            ecpd_pkg::M_IDLE:
            begin
                if (cmd.start)
                begin
                    case (cmd.op)
                        ecpd_pkg::OP_ADD:
                        begin
                            acc_next = sum;
                            st_next = ecpd_pkg::M_FIN;
                        end
                        ecpd_pkg::OP_SUB:
                        begin
                            acc_next = diff;
                            st_next = ecpd_pkg::M_ADDP;
                        end
                        default:
                        begin
                            prod_next = '0;
                            i_next = '0;
                            j_next = '0;
                            carry_next = '0;
                            st_next = ecpd_pkg::M_PROD;
                        end
                    endcase
                end
            end
            ecpd_pkg::M_PROD:
            begin
                prod_next[ij*L +: L] = cur[L-1:0];
                carry_next = cur[2*L-1:L];
                j_next = j_reg + 1'b1;
                if (&j_reg)
                begin
                    prod_next[(ij+1)*L +: L] = cur[2*L-1:L];
                    carry_next = '0;
                    j_next = '0;
                    i_next = i_reg + 1'b1;
                    if (&i_reg)
                    begin
                        k_next = '0;
                        top_next = '0;
                        acc_next = '0;
                        st_next = ecpd_pkg::M_RED;
                    end
                end
            end
            ecpd_pkg::M_RED:
            begin
                if (k_reg[ecpd_pkg::IDX_W])
                begin
                    top_next = racc[L+1:0];
                    st_next = ecpd_pkg::M_FOLD;
                end
                else
                begin
                    acc_next[k_reg[ecpd_pkg::IDX_W-1:0]*L +: L] = racc[L-1:0];
                    top_next = {2'b00, racc[2*L-1:L]};
                    k_next = k_reg + 1'b1;
                end
            end
            ecpd_pkg::M_FOLD:
            begin
                if (top_reg != '0)
                begin
                    acc_next = {1'b0, fsum[W-1:0]};
                    top_next = {{(L+1){1'b0}}, fsum[W]};
                end
                else
                begin
                    st_next = ecpd_pkg::M_FIN;
                end
            end
            ecpd_pkg::M_FIN:
            begin
                res_next = csub[W+1] ? acc_reg[W-1:0] : csub[W-1:0];
                done_next = 1'b1;
                st_next = ecpd_pkg::M_IDLE;
            end
            ecpd_pkg::M_ADDP:
            begin
                res_next = acc_reg[W] ? acc_reg[W-1:0] + ecpd_pkg::PRIME : acc_reg[W-1:0];
                done_next = 1'b1;
                st_next = ecpd_pkg::M_IDLE;
            end
            default:
            begin
                st_next = ecpd_pkg::M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ecpd_pkg::M_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start && st_reg == ecpd_pkg::M_IDLE)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
        prod_reg <= prod_next;
        carry_reg <= carry_next;
        top_reg <= top_next;
        res_reg <= res_next;
        acc_reg <= acc_next;
    end

    assign res = res_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

// ===== rtl/core/ec_point_double_affine.sv =====
// Top level: secp256k1 affine point doubling with a sequencer over one shared modular unit.
// Usage: an input point (x, y) is taken on s_axis as one transfer, 512 data bits with
// x in the low 256 bits and y above it, each least significant word first.
// The doubled point leaves on m_axis in the same layout.
// The block handles one point at a time: s_axis_tready is high only while idle.
// Each point takes 509 field multiplications (256 squarings and 249 multiplies for the
// inversion, plus four more); each one forms 64 partial products on the single 32x32
// multiplier, reduces limb by limb, folds the part above 2^256 back in and ends with
// a final subtract and the command handshake. Seven adds and subtracts come on top;
// the multiplier sets the time from input transfer to result valid.
// The result register holds its value while m_axis_tready is low, and the next
// point is taken at the earliest in the cycle after the result transfer.
// Reset returns the sequencer to idle and drops m_axis_tvalid.
// Inputs are reduced below p on entry; y equal to zero gives a zero slope.
`default_nettype none
module ec_point_double_affine (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // x_word0, x_word1, x_word2, x_word3, y_word0, y_word1, y_word2, y_word3
    input  wire logic [511:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // dbl_x_word0..dbl_x_word3, dbl_y_word0..dbl_y_word3
    output logic [511:0]      m_axis_tdata
);
    localparam int W = ecpd_pkg::FE_W;

    ecpd_pkg::state_t st_reg, st_next;
    logic [W-1:0] x_reg, y_reg, lam_reg, t_reg, acc_reg, nx_reg;
    logic [7:0] bit_reg;
    logic busy_reg, busy_next;
    logic [2*W-1:0] out_reg;
    logic ovalid_reg;
    ecpd_pkg::alu_cmd_t cmd;
    logic [W-1:0] opa, opb, res;
    logic done;

    ecpd_alu u_alu (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .a    (opa),
        .b    (opb),
        .res  (res),
        .done (done)
    );

    logic [W-1:0] xin, yin;
    always_comb
    begin
        xin = s_axis_tdata[W-1:0] >= ecpd_pkg::PRIME ? s_axis_tdata[W-1:0] - ecpd_pkg::PRIME
                                                     : s_axis_tdata[W-1:0];
        yin = s_axis_tdata[2*W-1:W] >= ecpd_pkg::PRIME ?
              s_axis_tdata[2*W-1:W] - ecpd_pkg::PRIME : s_axis_tdata[2*W-1:W];
    end

    // Next-state logic; every arithmetic state issues one command and waits for done.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ecpd_pkg::S_IDLE:
                if (s_axis_tvalid && !ovalid_reg) st_next = ecpd_pkg::S_X2;
            ecpd_pkg::S_X2:  if (done) st_next = ecpd_pkg::S_L2;
            ecpd_pkg::S_L2:  if (done) st_next = ecpd_pkg::S_L3;
            ecpd_pkg::S_L3:  if (done) st_next = ecpd_pkg::S_Y2;
            ecpd_pkg::S_Y2:  if (done) st_next = ecpd_pkg::S_INV_SQ;
            ecpd_pkg::S_INV_SQ:
                if (done)
                    st_next = ecpd_pkg::INV_EXP[bit_reg] ? ecpd_pkg::S_INV_MUL
                            : (bit_reg == 8'd0 ? ecpd_pkg::S_LAM : ecpd_pkg::S_INV_SQ);
            ecpd_pkg::S_INV_MUL:
                if (done) st_next = bit_reg == 8'd0 ? ecpd_pkg::S_LAM : ecpd_pkg::S_INV_SQ;
            ecpd_pkg::S_LAM:  if (done) st_next = ecpd_pkg::S_LSQ;
            ecpd_pkg::S_LSQ:  if (done) st_next = ecpd_pkg::S_SUB1;
            ecpd_pkg::S_SUB1: if (done) st_next = ecpd_pkg::S_SUB2;
            ecpd_pkg::S_SUB2: if (done) st_next = ecpd_pkg::S_SUB3;
            ecpd_pkg::S_SUB3: if (done) st_next = ecpd_pkg::S_YMUL;
            ecpd_pkg::S_YMUL: if (done) st_next = ecpd_pkg::S_SUB4;
            ecpd_pkg::S_SUB4: if (done) st_next = ecpd_pkg::S_IDLE;
            default: st_next = ecpd_pkg::S_IDLE;
        endcase
    end

    // Operand and command selection.
    always_comb
    begin
        busy_next = busy_reg;
        if (done) busy_next = 1'b0;
        cmd.start = 1'b0;
        cmd.op = ecpd_pkg::OP_MUL;
        opa = t_reg;
        opb = t_reg;
        case (st_reg)
            ecpd_pkg::S_X2:     begin opa = x_reg; opb = x_reg; end
            ecpd_pkg::S_L2:     begin cmd.op = ecpd_pkg::OP_ADD; opa = t_reg; opb = t_reg; end
            ecpd_pkg::S_L3:     begin cmd.op = ecpd_pkg::OP_ADD; opa = lam_reg; opb = t_reg; end
            ecpd_pkg::S_Y2:     begin cmd.op = ecpd_pkg::OP_ADD; opa = y_reg; opb = y_reg; end
            ecpd_pkg::S_INV_SQ: begin opa = acc_reg; opb = acc_reg; end
            ecpd_pkg::S_INV_MUL: begin opa = acc_reg; opb = t_reg; end
            ecpd_pkg::S_LAM:    begin opa = lam_reg; opb = acc_reg; end
            ecpd_pkg::S_LSQ:    begin opa = lam_reg; opb = lam_reg; end
            ecpd_pkg::S_SUB1:   begin cmd.op = ecpd_pkg::OP_SUB; opa = t_reg; opb = x_reg; end
            ecpd_pkg::S_SUB2:   begin cmd.op = ecpd_pkg::OP_SUB; opa = t_reg; opb = x_reg; end
            ecpd_pkg::S_SUB3:   begin cmd.op = ecpd_pkg::OP_SUB; opa = x_reg; opb = nx_reg; end
            ecpd_pkg::S_YMUL:   begin opa = lam_reg; opb = t_reg; end
            ecpd_pkg::S_SUB4:   begin cmd.op = ecpd_pkg::OP_SUB; opa = t_reg; opb = y_reg; end
            default: ;
        endcase
        if (st_reg != ecpd_pkg::S_IDLE && !busy_reg && !done)
        begin
            cmd.start = 1'b1;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ecpd_pkg::S_IDLE;
            busy_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            busy_reg <= busy_next;
            if (st_reg == ecpd_pkg::S_SUB4 && done) ovalid_reg <= 1'b1;
            else if (m_axis_tready) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            x_reg <= xin;
            y_reg <= yin;
            acc_reg <= {{(W-1){1'b0}}, 1'b1};
            bit_reg <= 8'd255;
        end
        if (done)
        begin
            case (st_reg)
                ecpd_pkg::S_X2:  t_reg <= res;
                ecpd_pkg::S_L2:  lam_reg <= res;
                ecpd_pkg::S_L3:  lam_reg <= res;
                ecpd_pkg::S_Y2:  t_reg <= res;
                ecpd_pkg::S_INV_SQ:
                begin
                    acc_reg <= res;
                    if (!ecpd_pkg::INV_EXP[bit_reg]) bit_reg <= bit_reg - 1'b1;
                end
                ecpd_pkg::S_INV_MUL:
                begin
                    acc_reg <= res;
                    bit_reg <= bit_reg - 1'b1;
                end
                ecpd_pkg::S_LAM:  lam_reg <= res;
                ecpd_pkg::S_LSQ:  t_reg <= res;
                ecpd_pkg::S_SUB1: t_reg <= res;
                ecpd_pkg::S_SUB2: nx_reg <= res;
                ecpd_pkg::S_SUB3: t_reg <= res;
                ecpd_pkg::S_YMUL: t_reg <= res;
                ecpd_pkg::S_SUB4: out_reg <= {res, nx_reg};
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (st_reg == ecpd_pkg::S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = out_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != ecpd_pkg::S_IDLE |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> st_reg != ecpd_pkg::S_IDLE)
        else $error("unit finished with no command");
endmodule
`default_nettype wire

// ===== bench/ec_point_double_affine_tb.sv =====
// Testbench for secp256k1 affine point doubling: directed table, curve-walk and random points.
`timescale 1ns / 100ps
module ec_point_double_affine_tb;
    localparam int DIRECTED_ROWS = 13;
    localparam int RANDOM_POINTS = 100;
    localparam logic [255:0] FIELD_P = ecpd_pkg::PRIME;
    localparam logic [255:0] ONES = {256{1'b1}};
    localparam logic [255:0] GEN_X =
        256'h79BE667E_F9DCBBAC_55A06295_CE870B07_029BFCDB_2DCE28D9_59F2815B_16F81798;
    localparam logic [255:0] GEN_Y =
        256'h483ADA77_26A3C465_5DA4FBFC_0E1108A8_FD17B448_A6855419_9C47D08F_FB10D4B8;

    typedef struct {
        logic [255:0] x;
        logic [255:0] y;
    } point_t;

    typedef struct {
        point_t pt;
        bit     known;
        point_t dbl;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [511:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [511:0] m_axis_tdata;

    point_t    pending_doubles[$];
    stim_row_t stim_table[DIRECTED_ROWS];
    int        mismatches;
    int        stall_left;

    ec_point_double_affine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Field arithmetic modulo p on wide vectors.
    function automatic logic [255:0] fe_reduce(input logic [255:0] v);
        return (v >= FIELD_P) ? v - FIELD_P : v;
    endfunction

    function automatic logic [255:0] fe_mul(input logic [255:0] a, input logic [255:0] b);
        logic [511:0] prod;
        prod = {256'd0, a} * {256'd0, b};
        return 256'(prod % {256'd0, FIELD_P});
    endfunction

    function automatic logic [255:0] fe_add(input logic [255:0] a, input logic [255:0] b);
        logic [256:0] s;
        s = {1'b0, a} + {1'b0, b};
        return 256'(s % {1'b0, FIELD_P});
    endfunction

    function automatic logic [255:0] fe_sub(input logic [255:0] a, input logic [255:0] b);
        return (a >= b) ? a - b : a + (FIELD_P - b);
    endfunction

    function automatic logic [255:0] fe_pow_inv(input logic [255:0] a);
        logic [255:0] acc;
        acc = 256'd1;
        for (int i = 255; i >= 0; i--)
        begin
            acc = fe_mul(acc, acc);
            if (ecpd_pkg::INV_EXP[i])
                acc = fe_mul(acc, a);
        end
        return acc;
    endfunction

    function automatic point_t double_point(input point_t p);
        logic [255:0] x, y, sq, slope, nx;
        point_t r;
        x = fe_reduce(p.x);
        y = fe_reduce(p.y);
        sq = fe_mul(x, x);
        slope = fe_add(fe_add(sq, sq), sq);
        // A zero y has no inverse; the exponentiation yields zero and so does the slope.
        slope = fe_mul(slope, fe_pow_inv(fe_add(y, y)));
        nx = fe_sub(fe_sub(fe_mul(slope, slope), x), x);
        r.x = nx;
        r.y = fe_sub(fe_mul(slope, fe_sub(x, nx)), y);
        return r;
    endfunction

    function automatic logic [255:0] rand_fe();
        logic [255:0] v;
        for (int i = 0; i < 8; i++)
            v[32*i +: 32] = $urandom;
        return v;
    endfunction

    task automatic send_point(input point_t p, input bit known, input point_t dbl);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.y, p.x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_doubles.push_back(known ? dbl : double_point(p));
    endtask

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Receiver stalls: mostly ready, short stalls, now and then a long one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 3);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Check every result transfer against the oldest expected double.
    always @(posedge clk)
    begin
        point_t want;
        logic [511:0] want_bits;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_doubles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %h", m_axis_tdata);
            end
            else
            begin
                want = pending_doubles.pop_front();
                want_bits = {want.y, want.x};
                for (int w = 0; w < 8; w++)
                begin
                    if (m_axis_tdata[64*w +: 64] !== want_bits[64*w +: 64])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d of %s: expected %h, got %h", w % 4,
                                     (w < 4) ? "x" : "y", want_bits[64*w +: 64],
                                     m_axis_tdata[64*w +: 64]);
                    end
                end
            end
        end
    end

    initial
    begin
        point_t pt;
        point_t walk;
        point_t none;
        int kind;
        stim_table[0]  = '{'{256'd0, 256'd0}, 1'b1, '{256'd0, 256'd0}};
        stim_table[1]  = '{'{256'd0, 256'd1}, 1'b1, '{256'd0, FIELD_P - 1}};
        stim_table[2]  = '{'{256'd0, FIELD_P - 1}, 1'b1, '{256'd0, 256'd1}};
        stim_table[3]  = '{'{256'd0, FIELD_P}, 1'b1, '{256'd0, 256'd0}};
        stim_table[4]  = '{'{ONES, 256'd0}, 1'b1, '{FIELD_P - 256'h2000007A0, 256'd0}};
        stim_table[5]  = '{'{256'd1, 256'd0}, 1'b1, '{FIELD_P - 2, 256'd0}};
        stim_table[6]  = '{'{FIELD_P - 1, 256'd0}, 1'b1, '{256'd2, 256'd0}};
        stim_table[7]  = '{'{ONES, ONES}, 1'b0, '{256'd0, 256'd0}};
        stim_table[8]  = '{'{FIELD_P - 1, FIELD_P - 1}, 1'b0, '{256'd0, 256'd0}};
        stim_table[9]  = '{'{GEN_X, GEN_Y}, 1'b0, '{256'd0, 256'd0}};
        stim_table[10] = '{'{FIELD_P, 256'd1}, 1'b1, '{256'd0, FIELD_P - 1}};
        stim_table[11] = '{'{256'd1 << 255, 256'd1}, 1'b0, '{256'd0, 256'd0}};
        stim_table[12] = '{'{256'd1, 256'd1}, 1'b0, '{256'd0, 256'd0}};
        none = '{256'd0, 256'd0};
        mismatches    = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_point(stim_table[i].pt, stim_table[i].known, stim_table[i].dbl);
            idle_gap();
        end

        // Most points walk the curve by repeated doubling of the generator.
        walk = '{GEN_X, GEN_Y};
        for (int n = 0; n < RANDOM_POINTS; n++)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                pt = walk;
                walk = double_point(walk);
            end
            else if (kind <= 7)
            begin
                pt = '{rand_fe(), rand_fe()};
            end
            else if (kind == 8)
            begin
                pt = '{FIELD_P + 256'($urandom_range(0, 977)), ONES - 256'($urandom)};
            end
            else
            begin
                pt = '{rand_fe(), ($urandom_range(0, 1) == 1) ? FIELD_P : 256'd0};
            end
            send_point(pt, 1'b0, none);
            idle_gap();
        end
        // The block stays busy long after a transfer, so one more edge with valid is harmless.
        @(posedge clk);
        s_axis_tvalid <= 1'b0;

        while (pending_doubles.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog for roughly 115 points on a 4 ns clock, taken several times over.
    initial
    begin
        #100_000_000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
